[hw/rtl/line_key_field_locator_core_defines.svh]
// Assertion macros for the line key field locator core RTL.
`ifndef LINE_KEY_FIELD_LOCATOR_CORE_DEFINES_SVH
`define LINE_KEY_FIELD_LOCATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define LKFL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked outside reset.
`define LKFL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LKFL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define LKFL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

[hw/rtl/lkfl_pkg.sv]
// Types and constants shared by the line key field locator modules.
`default_nettype none

package lkfl_pkg;

	localparam int unsigned BYTE_W = 8;

	typedef logic [BYTE_W-1:0] byte_t;

	localparam byte_t NEWLINE_BYTE = 8'd10;
	localparam byte_t BLANK_LIMIT  = 8'd32;

	// One result beat: where the key sits in the line and how long things are
	typedef struct packed {
		byte_t key_offset;
		byte_t key_length;
		byte_t line_length;
		logic  line_too_long;
	} lkfl_result_t;

endpackage

`default_nettype wire

[hw/rtl/line_key_field_locator_core.sv]
// Line key field locator top level: input register, line scan, result register.
//
//   channel  direction  payload                                        handshake
//   in       sink       byte_value                                     in_valid / in_ready
//   cfg      sink       word_number                                    cfg_valid / cfg_ready
//   out      source     key_offset key_length line_length line_too_long out_valid / out_ready
//
// One byte per clock sustained unless the input is held; a byte waits in the input
// register while the scan logic updates the line counters, a newline then loads the
// result register. A newline beat passes the input register, then the result register.
// Reset clears all line state and sets word_number to 1.
// Only a newline waiting on a full, stalled result register holds the input.
`default_nettype none

`include "line_key_field_locator_core_defines.svh"

module line_key_field_locator_core #(
	parameter int MAX_LINE = 128,
	parameter int MAX_KEY  = 128
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  lkfl_pkg::byte_t byte_value,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  lkfl_pkg::byte_t word_number,
	output logic            out_valid,
	input  logic            out_ready,
	output lkfl_pkg::byte_t key_offset,
	output lkfl_pkg::byte_t key_length,
	output lkfl_pkg::byte_t line_length,
	output logic            line_too_long
);
	import lkfl_pkg::*;

	localparam byte_t MaxLineC = byte_t'(MAX_LINE);
	localparam byte_t MaxKeyC  = byte_t'(MAX_KEY);

	byte_t        word_number_q;
	logic         valid_s1;
	byte_t        byte_s1;
	logic         line_end;
	logic         out_free;
	logic         advance_s1;
	lkfl_result_t scan_result;
	lkfl_result_t out_data;

	// Hold the key word number
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_number_q <= 8'd1;
		end else if (cfg_valid) begin
			word_number_q <= word_number;
		end
	end

	// Advance the input register unless a newline waits on a full result slot
	assign advance_s1 = valid_s1 && (!line_end || out_free);
	assign in_ready   = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= byte_value;
		end
	end

	lkfl_scan #(
		.MAX_LINE (MAX_LINE),
		.MAX_KEY  (MAX_KEY)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance_s1),
		.byte_s1     (byte_s1),
		.word_number (word_number_q),
		.line_end    (line_end),
		.result      (scan_result)
	);

	lkfl_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance_s1 && line_end),
		.load_data (scan_result),
		.free      (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign key_offset    = out_data.key_offset;
	assign key_length    = out_data.key_length;
	assign line_length   = out_data.line_length;
	assign line_too_long = out_data.line_too_long;

	// Checks
	`LKFL_ASSERT_IMP(a_len_bounds, clk, arst_n, out_valid,
		(line_length <= MaxLineC) && (key_length <= MaxKeyC), "result length out of range")
	`LKFL_ASSERT_IMP(a_key_in_line, clk, arst_n, out_valid,
		key_offset <= line_length, "key offset beyond line end")
	`LKFL_ASSERT_IMP(a_overflow_len, clk, arst_n, out_valid && line_too_long,
		line_length == MaxLineC, "overflowed line not saturated")
	`LKFL_ASSERT_IMP(a_stall_cause, clk, arst_n, !in_ready,
		valid_s1 && line_end && out_valid && !out_ready, "input stalled without cause")

endmodule

`default_nettype wire

[hw/rtl/lkfl_scan.sv]
// Per-line scan state: word tracking, key position and length, line length.
`default_nettype none

module lkfl_scan #(
	parameter int MAX_LINE = 128,
	parameter int MAX_KEY  = 128
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  lkfl_pkg::byte_t       byte_s1,
	input  lkfl_pkg::byte_t       word_number,
	output logic                  line_end,
	output lkfl_pkg::lkfl_result_t result
);
	import lkfl_pkg::*;

	localparam byte_t MaxLineC = byte_t'(MAX_LINE);
	localparam byte_t MaxKeyC  = byte_t'(MAX_KEY);

	byte_t line_position_q;
	byte_t word_count_q;
	byte_t key_start_q;
	byte_t key_bytes_q;
	logic  key_counting_q;
	logic  prev_blank_q;
	logic  overflowed_q;

	byte_t line_position_d;
	byte_t word_count_d;
	byte_t key_start_d;
	byte_t key_bytes_d;
	logic  key_counting_d;
	logic  prev_blank_d;
	logic  overflowed_d;

	logic  blank;
	logic  new_word;

	assign line_end = (byte_s1 == NEWLINE_BYTE);
	assign blank    = (byte_s1 <= BLANK_LIMIT);
	assign new_word = !blank && prev_blank_q && (word_count_q < word_number);

	// Report the finished line
	assign result.key_offset    = key_start_q;
	assign result.key_length    = key_bytes_q;
	assign result.line_length   = line_position_q;
	assign result.line_too_long = overflowed_q;

	// Advance the line state by one byte
	always_comb begin
		line_position_d = line_position_q;
		word_count_d    = word_count_q;
		key_start_d     = key_start_q;
		key_bytes_d     = key_bytes_q;
		key_counting_d  = key_counting_q;
		prev_blank_d    = prev_blank_q;
		overflowed_d    = overflowed_q;
		if (line_end) begin
			line_position_d = '0;
			word_count_d    = 8'd1;
			key_start_d     = '0;
			key_bytes_d     = '0;
			key_counting_d  = 1'b1;
			prev_blank_d    = 1'b0;
			overflowed_d    = 1'b0;
		end else if (line_position_q >= MaxLineC) begin
			overflowed_d = 1'b1;
		end else begin
			if (new_word) begin
				word_count_d   = word_count_q + 8'd1;
				key_start_d    = line_position_q;
				key_bytes_d    = '0;
				key_counting_d = 1'b1;
			end
			// Count key bytes until the first blank after the key start
			if (key_counting_d) begin
				if (blank) begin
					key_counting_d = 1'b0;
				end else if (key_bytes_d < MaxKeyC) begin
					key_bytes_d = key_bytes_d + 8'd1;
				end
			end
			prev_blank_d    = blank;
			line_position_d = line_position_q + 8'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_position_q <= '0;
			word_count_q    <= 8'd1;
			key_start_q     <= '0;
			key_bytes_q     <= '0;
			key_counting_q  <= 1'b1;
			prev_blank_q    <= 1'b0;
			overflowed_q    <= 1'b0;
		end else if (step) begin
			line_position_q <= line_position_d;
			word_count_q    <= word_count_d;
			key_start_q     <= key_start_d;
			key_bytes_q     <= key_bytes_d;
			key_counting_q  <= key_counting_d;
			prev_blank_q    <= prev_blank_d;
			overflowed_q    <= overflowed_d;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/lkfl_out_stage.sv]
// Result register: holds one result beat until the consumer takes it.
`default_nettype none

module lkfl_out_stage (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  lkfl_pkg::lkfl_result_t load_data,
	output logic                   free,
	output logic                   out_valid,
	input  logic                   out_ready,
	output lkfl_pkg::lkfl_result_t out_data
);
	import lkfl_pkg::*;

	logic         valid_q;
	lkfl_result_t data_q;

	assign free      = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	// Drop the beat once taken, load a new one when free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end
	end

endmodule

`default_nettype wire

[tb/tb_line_key_field_locator_core.sv]
`timescale 1ns / 100ps
// Testbench for the line key field locator core: random text lines against a line scan model.
module tb_line_key_field_locator_core;
	import lkfl_pkg::*;

	localparam int LINE_CAP      = 128;
	localparam int KEY_CAP       = 128;
	localparam int SETTLE_CYCLES = 6;
	localparam int STALL_LIMIT   = 2000;
	localparam int PHASE_BYTES   = 230;
	localparam int NUM_PHASES    = 6;
	localparam int REPORT_MAX    = 40;

	// Directed bytes: empty line, leading blank, field edges, blank and byte extremes
	localparam byte_t DIRECTED[16] = '{
		NEWLINE_BYTE,
		BLANK_LIMIT, 8'd33, 8'd255, NEWLINE_BYTE,
		8'd255, 8'd0, 8'd33, NEWLINE_BYTE,
		8'd128, 8'd127, BLANK_LIMIT, 8'd31, NEWLINE_BYTE,
		8'd0, NEWLINE_BYTE
	};

	logic  clk         = 1'b0;
	logic  arst_n      = 1'b0;
	logic  in_valid    = 1'b0;
	logic  in_ready;
	byte_t byte_value  = '0;
	logic  cfg_valid   = 1'b0;
	logic  cfg_ready;
	byte_t word_number = '0;
	logic  out_valid;
	logic  out_ready   = 1'b0;
	byte_t key_offset;
	byte_t key_length;
	byte_t line_length;
	logic  line_too_long;

	byte_t        pending_bytes[$];
	lkfl_result_t expected_lines[$];

	int send_idle_pct = 24;
	int recv_idle_pct = 80;
	int mismatches    = 0;
	int stall_cycles  = 0;

	// Line scan state, mirrored from the block
	int   sel_word     = 1;
	int   line_pos     = 0;
	int   word_cnt     = 1;
	int   key_start    = 0;
	int   key_bytes    = 0;
	logic key_counting = 1'b1;
	logic prev_blank   = 1'b0;
	logic overflowed   = 1'b0;

	line_key_field_locator_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.byte_value    (byte_value),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.word_number   (word_number),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.key_offset    (key_offset),
		.key_length    (key_length),
		.line_length   (line_length),
		.line_too_long (line_too_long)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Any blank byte except the newline
	function automatic byte_t pick_blank();
		int v;
		v = $urandom_range(31);
		if (v >= NEWLINE_BYTE) begin
			v = v + 1;
		end
		return byte_t'(v);
	endfunction

	// Hold until every queued byte is sent and every line result is back, then settle
	task automatic wait_drained();
		while (pending_bytes.size() != 0 || in_valid || expected_lines.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Byte driver; predicts each accepted beat and tracks register writes
	always @(posedge clk) begin
		lkfl_result_t res;
		logic         blank;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				sel_word = word_number;
			end
			if (in_valid && in_ready) begin
				if (byte_value == NEWLINE_BYTE) begin
					res.key_offset    = byte_t'(key_start);
					res.key_length    = byte_t'(key_bytes);
					res.line_length   = byte_t'(line_pos);
					res.line_too_long = overflowed;
					expected_lines.push_back(res);
					line_pos     = 0;
					word_cnt     = 1;
					key_start    = 0;
					key_bytes    = 0;
					key_counting = 1'b1;
					prev_blank   = 1'b0;
					overflowed   = 1'b0;
				end else if (line_pos >= LINE_CAP) begin
					// past the line cap only the overflow flag moves
					overflowed = 1'b1;
				end else begin
					blank = (byte_value <= BLANK_LIMIT);
					if (!blank && prev_blank && word_cnt < sel_word) begin
						word_cnt     = word_cnt + 1;
						key_start    = line_pos;
						key_bytes    = 0;
						key_counting = 1'b1;
					end
					if (key_counting) begin
						if (blank) begin
							key_counting = 1'b0;
						end else if (key_bytes < KEY_CAP) begin
							key_bytes = key_bytes + 1;
						end
					end
					prev_blank = blank;
					line_pos   = line_pos + 1;
				end
			end
			// Advance to the next byte only once the current beat is gone
			if (!in_valid || in_ready) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid   <= 1'b1;
					byte_value <= pending_bytes.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compare each beat with the oldest expected line
	always @(posedge clk) begin
		lkfl_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_lines.size() == 0) begin
					if (mismatches < REPORT_MAX) begin
						$display("%0t: unexpected result, expected none, actual %0d %0d %0d %0d",
							$time, key_offset, key_length, line_length, line_too_long);
					end
					mismatches++;
				end else begin
					want = expected_lines.pop_front();
					if (key_offset !== want.key_offset) begin
						if (mismatches < REPORT_MAX) begin
							$display("%0t: key_offset expected %0d actual %0d",
								$time, want.key_offset, key_offset);
						end
						mismatches++;
					end
					if (key_length !== want.key_length) begin
						if (mismatches < REPORT_MAX) begin
							$display("%0t: key_length expected %0d actual %0d",
								$time, want.key_length, key_length);
						end
						mismatches++;
					end
					if (line_length !== want.line_length) begin
						if (mismatches < REPORT_MAX) begin
							$display("%0t: line_length expected %0d actual %0d",
								$time, want.line_length, line_length);
						end
						mismatches++;
					end
					if (line_too_long !== want.line_too_long) begin
						if (mismatches < REPORT_MAX) begin
							$display("%0t: line_too_long expected %0d actual %0d",
								$time, want.line_too_long, line_too_long);
						end
						mismatches++;
					end
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
		// Count cycles with no beat on any channel
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
		end
		$display("FAIL line_key_field_locator_core");
		$finish;
	end

	initial begin
		int   wn_set[NUM_PHASES];
		int   wn;
		int   phase_bytes;
		int   queued_at_start;
		int   kind;
		int   len;
		int   nwords;
		logic solid;
		logic paused;

		paused = 1'b0;
		wn_set = '{2, 255, 0, 1, $urandom_range(3, 8), $urandom_range(1, 255)};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed lines at the reset word number
		foreach (DIRECTED[i]) begin
			pending_bytes.push_back(DIRECTED[i]);
		end
		wait_drained();

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p / 2)
				0: begin
					send_idle_pct = 24;
					recv_idle_pct = 80;
				end
				1: begin
					send_idle_pct = 80;
					recv_idle_pct = 24;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase

			// Write the key word number while the block is idle
			wn = wn_set[p];
			@(posedge clk);
			cfg_valid   <= 1'b1;
			word_number <= byte_t'(wn);
			do @(posedge clk); while (!cfg_ready);
			cfg_valid <= 1'b0;

			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES) begin
				queued_at_start = pending_bytes.size();
				kind            = $urandom_range(99);
				if (kind < 6) begin
					// long line around and past the line cap
					case ($urandom_range(3))
						0: len = LINE_CAP - 1;
						1: len = LINE_CAP;
						2: len = LINE_CAP + 1;
						default: len = $urandom_range(LINE_CAP + 2, LINE_CAP + 52);
					endcase
					solid = $urandom_range(1);
					for (int i = 0; i < len; i++) begin
						if (solid || $urandom_range(4) != 0) begin
							pending_bytes.push_back(byte_t'($urandom_range(33, 255)));
						end else begin
							pending_bytes.push_back(pick_blank());
						end
					end
				end else if (kind < 18) begin
					// noise: any byte values, stray newlines included
					len = $urandom_range(30);
					for (int i = 0; i < len; i++) begin
						pending_bytes.push_back(byte_t'($urandom_range(255)));
					end
				end else begin
					// well-formed words with blank runs between them
					if ($urandom_range(3) == 0) begin
						repeat ($urandom_range(1, 3)) pending_bytes.push_back(pick_blank());
					end
					nwords = $urandom_range(0, ((wn < 6) ? wn : 6) + 2);
					for (int w = 0; w < nwords; w++) begin
						if (w > 0) begin
							repeat ($urandom_range(1, 3)) pending_bytes.push_back(pick_blank());
						end
						repeat ($urandom_range(1, 10)) begin
							pending_bytes.push_back(byte_t'($urandom_range(33, 255)));
						end
					end
					if ($urandom_range(3) == 0) begin
						repeat ($urandom_range(1, 3)) pending_bytes.push_back(pick_blank());
					end
				end
				pending_bytes.push_back(NEWLINE_BYTE);
				phase_bytes += pending_bytes.size() - queued_at_start;

				// Hold the sender once mid-phase until every result is back
				if (p == 2 && !paused && phase_bytes >= PHASE_BYTES / 2) begin
					wait_drained();
					paused = 1'b1;
				end
			end
			wait_drained();
		end

		if (mismatches == 0 && expected_lines.size() == 0) begin
			$display("PASS line_key_field_locator_core");
		end else begin
			$display("FAIL line_key_field_locator_core");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/lkfl_pkg.sv
hw/rtl/lkfl_scan.sv
hw/rtl/lkfl_out_stage.sv
hw/rtl/line_key_field_locator_core.sv
tb/tb_line_key_field_locator_core.sv
